// ===== src/nflr_pkg.sv =====
// ----------------------------------------------------------------------------
// nflr_pkg
// Shared types and constants for the newest-first post code ring log.
// ----------------------------------------------------------------------------
package nflr_pkg;

  localparam int DEF_LOG_DEPTH      = 1024;
  localparam int DEF_MAX_READ_WORDS = 64;

  localparam int CODE_W  = 32;
  localparam int START_W = 10;
  localparam int COUNT_W = 7;
  localparam int CAP_W   = 16;
  localparam int BYTES_W = 9;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_READ     = 2'd1,
    REQ_CLR_FILL = 2'd2,
    REQ_CLR_FLAG = 2'd3
  } req_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    req_t               req_type;
    logic [CODE_W-1:0]  code_word;
    logic [START_W-1:0] start_offset;
    logic [COUNT_W-1:0] word_count;
    logic [CAP_W-1:0]   capacity_bytes;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0]  entry_word;
    logic               entry_valid;
    logic               last_result;
    logic [BYTES_W-1:0] bytes_returned;
    logic               code_seen;
  } out_word_t;

  // Controller to output stage
  typedef struct packed {
    logic               direct;       // load direct_word into the output register
    out_word_t          direct_word;
    logic               rd_issue;     // ring read issued this cycle
    logic               rd_last;
    logic [BYTES_W-1:0] rd_bytes;
    logic               rd_seen;
  } issue_t;

  // Output stage to controller
  typedef struct packed {
    logic out_free;     // output register can take a word this cycle
    logic stage_free;   // read data stage can take a new read this cycle
    logic stage_empty;  // no read data pending
  } status_t;

endpackage

// ===== src/nflr_ram.sv =====
// ----------------------------------------------------------------------------
// nflr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nflr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/nflr_ctrl.sv =====
// ----------------------------------------------------------------------------
// nflr_ctrl
// Request decode, ring pointers, fill count, received flag and read sequencer.
// ----------------------------------------------------------------------------
module nflr_ctrl import nflr_pkg::*; #(
  parameter int LOG_DEPTH      = DEF_LOG_DEPTH,
  parameter int MAX_READ_WORDS = DEF_MAX_READ_WORDS,
  localparam int PW            = $clog2(LOG_DEPTH),
  localparam int CW            = $clog2(LOG_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  in_word_t          req,
  input  status_t           status,
  output issue_t            issue,
  output logic              ram_we,
  output logic [PW-1:0]     ram_waddr,
  output logic [CODE_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [PW-1:0]     ram_raddr
);

  localparam int SW = (CW > START_W) ? CW : START_W;
  localparam int AW = ((PW > START_W) ? PW : START_W) + 2;

  state_t state, state_next;

  logic [PW-1:0]      wp, wp_next;
  logic [CW-1:0]      fill, fill_next;
  logic               seen, seen_next;
  logic [PW-1:0]      rd_idx;
  logic [COUNT_W-1:0] rd_left;
  logic [BYTES_W-1:0] rd_bytes;
  logic               rd_last;

  logic               accept;
  logic               is_read;
  logic [SW-1:0]      fill_ext, start_ext, avail;
  logic               start_ok, cap_ok;
  logic [COUNT_W-1:0] lim, n_words;
  logic [AW-1:0]      back;
  logic [PW-1:0]      start_idx;

  // Take a new word only with the whole read path drained.
  assign req_stall = !((state == ST_IDLE) && status.out_free && status.stage_empty);
  assign accept    = req_valid && !req_stall;
  assign is_read   = (req.req_type == REQ_READ);
  assign rd_last   = (rd_left == COUNT_W'(1));

  // Entry count of a read
  assign fill_ext  = SW'(fill);
  assign start_ext = SW'(req.start_offset);
  assign start_ok  = start_ext < fill_ext;
  assign avail     = fill_ext - start_ext;
  assign cap_ok    = req.capacity_bytes >= CAP_W'({req.word_count, 2'b00});
  assign lim       = (req.word_count > COUNT_W'(MAX_READ_WORDS)) ?
                     COUNT_W'(MAX_READ_WORDS) : req.word_count;
  assign n_words   = !(cap_ok && start_ok) ? '0 :
                     (avail < SW'(lim)) ? COUNT_W'(avail) : lim;

  // Newest entry sits just below the write pointer; step back by the offset.
  assign back      = AW'(wp) - AW'(1) - AW'(req.start_offset);
  assign start_idx = back[AW-1] ? PW'(back + AW'(LOG_DEPTH)) : PW'(back);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_read && (n_words != '0)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (status.stage_free && rd_last) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Pointer, fill and flag updates
  always_comb begin
    wp_next   = wp;
    fill_next = fill;
    seen_next = seen;
    if (accept) begin
      unique case (req.req_type)
        REQ_INSERT: begin
          seen_next = 1'b1;
          wp_next   = (wp == PW'(LOG_DEPTH - 1)) ? '0 : wp + 1'b1;
          if (fill != CW'(LOG_DEPTH)) begin
            fill_next = fill + 1'b1;
          end
        end
        REQ_READ: begin
        end
        REQ_CLR_FILL: begin
          fill_next = '0;
        end
        REQ_CLR_FLAG: begin
          seen_next = 1'b0;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    ram_we    = accept && (req.req_type == REQ_INSERT);
    ram_waddr = wp;
    ram_wdata = req.code_word;
    ram_re    = (state == ST_READ) && status.stage_free;
    ram_raddr = rd_idx;

    issue.direct                     = accept && !(is_read && (n_words != '0));
    issue.direct_word.entry_word     = '0;
    issue.direct_word.entry_valid    = 1'b0;
    issue.direct_word.last_result    = 1'b1;
    issue.direct_word.bytes_returned = '0;
    issue.direct_word.code_seen      = seen_next;
    issue.rd_issue                   = ram_re;
    issue.rd_last                    = rd_last;
    issue.rd_bytes                   = rd_last ? rd_bytes : '0;
    issue.rd_seen                    = seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wp      <= '0;
      fill    <= '0;
      seen    <= 1'b0;
      rd_left <= '0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      fill  <= fill_next;
      seen  <= seen_next;
      if (accept && is_read) begin
        rd_left <= n_words;
      end else if (ram_re) begin
        rd_left <= rd_left - 1'b1;
      end
    end
  end

  // Read cursor walks toward older entries, wrapping below zero.
  always_ff @(posedge clk) begin
    if (accept && is_read) begin
      rd_idx   <= start_idx;
      rd_bytes <= BYTES_W'({n_words, 2'b00});
    end else if (ram_re) begin
      rd_idx <= (rd_idx == '0) ? PW'(LOG_DEPTH - 1) : rd_idx - 1'b1;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(LOG_DEPTH))
    else $error("fill count above ring depth");

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    wp <= PW'(LOG_DEPTH - 1))
    else $error("write pointer out of ring");

  a_read_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (rd_left != '0))
    else $error("read sequencer running with nothing left");

  a_no_write_in_read: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE) && !ram_re)
    else $error("ring write overlaps a read sequence");

endmodule

// ===== src/nflr_out.sv =====
// ----------------------------------------------------------------------------
// nflr_out
// Read data stage behind the ring RAM and the output register.
// ----------------------------------------------------------------------------
module nflr_out import nflr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  issue_t            issue,
  input  logic [CODE_W-1:0] ram_rdata,
  output status_t           status,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output out_word_t         rsp
);

  logic               stage_vld;
  logic               stage_last;
  logic [BYTES_W-1:0] stage_bytes;
  logic               stage_seen;
  logic               out_free;
  logic               move;

  // RAM read data holds until the next read, so it serves as the stage data.
  assign out_free           = !rsp_valid || !rsp_stall;
  assign move               = stage_vld && out_free;
  assign status.out_free    = out_free;
  assign status.stage_free  = !stage_vld || move;
  assign status.stage_empty = !stage_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      stage_vld <= issue.rd_issue || (stage_vld && !move);
      rsp_valid <= move || issue.direct || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (issue.rd_issue) begin
      stage_last  <= issue.rd_last;
      stage_bytes <= issue.rd_bytes;
      stage_seen  <= issue.rd_seen;
    end
    if (move) begin
      rsp.entry_word     <= ram_rdata;
      rsp.entry_valid    <= 1'b1;
      rsp.last_result    <= stage_last;
      rsp.bytes_returned <= stage_bytes;
      rsp.code_seen      <= stage_seen;
    end else if (issue.direct) begin
      rsp <= issue.direct_word;
    end
  end

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(issue.direct && stage_vld))
    else $error("direct word collides with pending read data");

  a_direct_room: assert property (@(posedge clk) disable iff (rst)
    issue.direct |-> out_free)
    else $error("direct word issued into a full output register");

  a_issue_room: assert property (@(posedge clk) disable iff (rst)
    issue.rd_issue |-> (!stage_vld || move))
    else $error("ring read issued over pending read data");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stage_vld && !out_free) |=> stage_vld)
    else $error("pending read data dropped");

endmodule

// ===== src/newest_first_log_ring_core.sv =====
// ----------------------------------------------------------------------------
// newest_first_log_ring_core
// Ring log of 32-bit post codes, read back newest first.
// ----------------------------------------------------------------------------
// Each request word is an insert, a history read, a fill count clear or a
// received flag clear. Insert, both clears and any read that returns no
// entries each give a single response word, so they run back to back while
// the response side keeps up; a new request is taken in the cycle the
// previous response word leaves the output register, and waits while that
// word is stalled. A read that returns n entries streams one entry per cycle
// from the single read port of the ring RAM while the response side does not
// stall, and takes no new request until it is done: it accepts and sets up
// the read cursor, issues n reads, and drains the RAM read stage. The ring
// RAM is not cleared at reset (no clearing pass); entries beyond the fill
// count are never read, so stale contents are never seen. Writes happen only
// on accepted inserts, which cannot overlap a read sequence, so no forwarding
// is needed.
// ----------------------------------------------------------------------------
module newest_first_log_ring_core import nflr_pkg::*; #(
  parameter int LOG_DEPTH      = DEF_LOG_DEPTH,
  parameter int MAX_READ_WORDS = DEF_MAX_READ_WORDS
) (
  input  logic      clk,
  input  logic      rst,
  // request channel
  input  logic      req_valid,
  output logic      req_stall,
  input  in_word_t  req,
  // response channel
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_word_t rsp
);

  localparam int PW = $clog2(LOG_DEPTH);

  status_t           status;
  issue_t            issue;
  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PW-1:0]     ram_raddr;
  logic [CODE_W-1:0] ram_rdata;

  // Decode requests, keep pointers and flag, sequence reads.
  nflr_ctrl #(
    .LOG_DEPTH      (LOG_DEPTH),
    .MAX_READ_WORDS (MAX_READ_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .status    (status),
    .issue     (issue),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // Code history ring
  nflr_ram #(
    .WIDTH (CODE_W),
    .DEPTH (LOG_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold read data and the response word until taken.
  nflr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .ram_rdata (ram_rdata),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
